// ----- sv/lrd_pkg.sv -----
package lrd_pkg;

   localparam int unsigned DATA_W   = 8;
   localparam int unsigned LEN_W    = 32;
   localparam int unsigned CRC_W    = 32;
   localparam int unsigned OFFSET_W = 64;
   localparam int unsigned KIND_W   = 3;

   localparam logic [CRC_W-1:0]    CRC32C_POLY  = 32'h82F6_3B78;
   localparam logic [CRC_W-1:0]    CRC_INIT     = 32'hFFFF_FFFF;
   localparam logic [LEN_W-1:0]    MAX_LEN_RST  = 32'd67108864;
   localparam logic [OFFSET_W-1:0] HDR_OVERHEAD = 64'd8;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_STOPPED = 3'b100
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE     = 3'd0,
      KIND_GOOD     = 3'd1,
      KIND_MISMATCH = 3'd2,
      KIND_EMPTY    = 3'd3,
      KIND_TOO_BIG  = 3'd4,
      KIND_END      = 3'd5
   } kind_type;

   // Reflected CRC-32C update over one byte, least significant bit first.
   function automatic logic [CRC_W-1:0] crc32c_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [DATA_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-DATA_W){1'b0}}, b};
      for (int i = 0; i < DATA_W; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC32C_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- sv/log_record_deframer_crc32c.sv -----
// Length-prefixed log record deframer with CRC-32C check. Each byte beat on
// req_ enters an input register and is decoded from there into a result
// register on rsp_, so one byte is taken every cycle while no result beat is
// stalled; the bytewise CRC-32C update and the header decode sit between
// those two registers. A byte waits in the input register only while a
// result beat is held by rsp_tready. Header bytes give no result beat, except
// an eighth header byte that reports an empty or oversize record, and an
// end-of-file beat reports the end; beats after the block has stopped give
// none. Payload bytes stream out at once, so a consumer discards a record
// whose final beat reports a checksum mismatch. After end of file or any
// corruption the block stops until reset. The user writes max_payload_length
// through csr_we/csr_wdata only while the block is idle; it is not enforced.
module log_record_deframer_crc32c
   import lrd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 csr_we,
   input  logic [LEN_W-1:0]     csr_wdata,   // max_payload_length

   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,   // [7:0] data_byte
   input  logic                 req_tlast,   // end_of_file

   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [71:0]          rsp_tdata,   // [7:0] payload_byte, [71:8] valid_offset
   output logic                 rsp_tlast,   // last_of_record
   output logic [KIND_W-1:0]    rsp_tuser    // [2:0] kind
);

   logic [LEN_W-1:0]    max_len_ff;

   logic                s1_valid_ff, s1_valid_in;
   logic [DATA_W-1:0]   s1_byte_ff;
   logic                s1_eof_ff;

   phase_type           phase_ff, phase_in;
   logic [2:0]          hdr_count_ff, hdr_count_in;
   logic [LEN_W-1:0]    len_shift_ff, len_shift_in;
   logic [CRC_W-1:0]    exp_crc_ff, exp_crc_in;
   logic [LEN_W-1:0]    bytes_left_ff, bytes_left_in;
   logic [CRC_W-1:0]    run_crc_ff, run_crc_in;
   logic [OFFSET_W-1:0] good_off_ff, good_off_in;

   logic                out_valid_ff, out_valid_in;
   kind_type            out_kind_ff, out_kind_in;
   logic [DATA_W-1:0]   out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;
   logic [OFFSET_W-1:0] out_off_ff, out_off_in;

   logic                out_free;
   logic                s1_go;
   logic                res_valid;
   logic [CRC_W-1:0]    crc_next;
   logic [CRC_W-1:0]    exp_crc_full;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   assign crc_next     = crc32c_byte(run_crc_ff, s1_byte_ff);
   assign exp_crc_full = {s1_byte_ff, exp_crc_ff[CRC_W-1:DATA_W]};

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      phase_in      = phase_ff;
      hdr_count_in  = hdr_count_ff;
      len_shift_in  = len_shift_ff;
      exp_crc_in    = exp_crc_ff;
      bytes_left_in = bytes_left_ff;
      run_crc_in    = run_crc_ff;
      good_off_in   = good_off_ff;
      res_valid     = 1'b0;
      out_kind_in   = KIND_BYTE;
      out_byte_in   = '0;
      out_last_in   = 1'b0;

      if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end

      if (s1_go) begin
         case (phase_ff)
            PH_HEADER: begin
               if (s1_eof_ff) begin
                  phase_in    = PH_STOPPED;
                  res_valid   = 1'b1;
                  out_kind_in = KIND_END;
               end else begin
                  hdr_count_in = hdr_count_ff + 3'd1;
                  if (!hdr_count_ff[2]) begin
                     len_shift_in = {s1_byte_ff, len_shift_ff[LEN_W-1:DATA_W]};
                  end else begin
                     exp_crc_in = exp_crc_full;
                  end
                  // The eighth header byte completes the expected CRC; the
                  // length has been complete since the fourth.
                  if (hdr_count_ff == 3'd7) begin
                     if (len_shift_ff == '0) begin
                        phase_in    = PH_STOPPED;
                        res_valid   = 1'b1;
                        out_kind_in = KIND_EMPTY;
                     end else if (len_shift_ff > max_len_ff) begin
                        phase_in    = PH_STOPPED;
                        res_valid   = 1'b1;
                        out_kind_in = KIND_TOO_BIG;
                     end else begin
                        phase_in      = PH_PAYLOAD;
                        bytes_left_in = len_shift_ff;
                        run_crc_in    = CRC_INIT;
                     end
                  end
               end
            end
            PH_PAYLOAD: begin
               if (s1_eof_ff) begin
                  phase_in    = PH_STOPPED;
                  res_valid   = 1'b1;
                  out_kind_in = KIND_END;
               end else begin
                  run_crc_in    = crc_next;
                  bytes_left_in = bytes_left_ff - LEN_W'(1);
                  res_valid     = 1'b1;
                  out_byte_in   = s1_byte_ff;
                  if (bytes_left_ff != LEN_W'(1)) begin
                     out_kind_in = KIND_BYTE;
                  end else if (~crc_next == exp_crc_ff) begin
                     out_kind_in  = KIND_GOOD;
                     out_last_in  = 1'b1;
                     good_off_in  = good_off_ff + HDR_OVERHEAD
                                    + {{(OFFSET_W-LEN_W){1'b0}}, len_shift_ff};
                     phase_in     = PH_HEADER;
                     hdr_count_in = '0;
                     run_crc_in   = CRC_INIT;
                  end else begin
                     out_kind_in = KIND_MISMATCH;
                     out_last_in = 1'b1;
                     phase_in    = PH_STOPPED;
                  end
               end
            end
            default: begin
               // Stopped: the beat is consumed without a result.
            end
         endcase
      end

      out_off_in = good_off_in;

      if (res_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff    <= MAX_LEN_RST;
         s1_valid_ff   <= 1'b0;
         phase_ff      <= PH_HEADER;
         hdr_count_ff  <= '0;
         len_shift_ff  <= '0;
         exp_crc_ff    <= '0;
         bytes_left_ff <= '0;
         run_crc_ff    <= CRC_INIT;
         good_off_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            max_len_ff <= csr_wdata;
         end
         s1_valid_ff   <= s1_valid_in;
         phase_ff      <= phase_in;
         hdr_count_ff  <= hdr_count_in;
         len_shift_ff  <= len_shift_in;
         exp_crc_ff    <= exp_crc_in;
         bytes_left_ff <= bytes_left_in;
         run_crc_ff    <= run_crc_in;
         good_off_ff   <= good_off_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_eof_ff  <= req_tlast;
      end
      if (res_valid) begin
         out_kind_ff <= out_kind_in;
         out_byte_ff <= out_byte_in;
         out_last_ff <= out_last_in;
         out_off_ff  <= out_off_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_off_ff, out_byte_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_kind_ff;

`ifndef SYNTHESIS
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_STOPPED && !out_valid_ff) |=> !out_valid_ff)
      else $error("result produced after the block stopped");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == KIND_GOOD || rsp_tuser == KIND_MISMATCH))
      else $error("record end flagged on a beat that is not a verdict");

   a_status_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_END || rsp_tuser == KIND_EMPTY
                      || rsp_tuser == KIND_TOO_BIG)) |-> (rsp_tdata[7:0] == '0 && !rsp_tlast))
      else $error("status beat carries payload fields");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_byte_ff)
                                      && $stable(s1_eof_ff)))
      else $error("input register lost a beat while the output stalled");

   a_offset_on_good: assert property (@(posedge clock) disable iff (reset)
      (good_off_ff != $past(good_off_ff)) |-> (out_valid_ff && out_kind_ff == KIND_GOOD))
      else $error("valid offset moved without a good record");
`endif

endmodule
